/* rtl/free_page_stack_allocator_macros.svh */
// ---------------------------------------------------------------------------
// free page stack allocator assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef FREE_PAGE_STACK_ALLOCATOR_MACROS_SVH
`define FREE_PAGE_STACK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define FPSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define FPSA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define FPSA_ASSERT(label, clk, rst, prop)
`define FPSA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* rtl/fpsa_pkg.sv */
// ---------------------------------------------------------------------------
// fpsa_pkg
// shared constants, codes and helpers of the free page stack allocator
// ---------------------------------------------------------------------------
package fpsa_pkg;

   localparam int MAX_PAGES  = 32768;
   localparam int PAGE_SHIFT = 12;

   localparam int ADDR_W   = 32;
   localparam int BYTES_W  = 33;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int PN_W     = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W    = $clog2(MAX_PAGES);
   localparam int COUNT_W  = $clog2(MAX_PAGES + 1);

   localparam logic [ADDR_W-1:0] LOWER_RESET = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] UPPER_RESET = 32'h8800_0000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_FREE  = 2'd0,
      ACT_ALLOC = 2'd1,
      ACT_LOAD  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 2'd0,
      STS_BADADDR  = 2'd1,
      STS_EMPTY    = 2'd2,
      STS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOWER = 1'd0,
      CSR_UPPER = 1'd1
   } csr_index_type;

   // free page count to byte count
   function automatic logic [BYTES_W-1:0] bytes_of(input logic [COUNT_W-1:0] count);
      bytes_of = BYTES_W'(count) << PAGE_SHIFT;
   endfunction

endpackage

/* rtl/fpsa_if.sv */
// ---------------------------------------------------------------------------
// fpsa channel interfaces
// valid/ready channels for requests, responses and register writes
// ---------------------------------------------------------------------------
interface fpsa_req_if;
   import fpsa_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   page_addr;
   modport source (output valid, action, page_addr, input ready);
   modport sink   (input valid, action, page_addr, output ready);
endinterface

interface fpsa_rsp_if;
   import fpsa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   alloc_addr;
   logic [BYTES_W-1:0]  free_bytes;
   modport source (output valid, status, alloc_addr, free_bytes, input ready);
   modport sink   (input valid, status, alloc_addr, free_bytes, output ready);
endinterface

interface fpsa_csr_if;
   import fpsa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/free_page_stack_allocator.sv */
// ---------------------------------------------------------------------------
// free_page_stack_allocator
// physical page allocator keeping free page numbers in a lifo stack
// ---------------------------------------------------------------------------
// usage
//   req_if: one item per request, action free / alloc / load and page_addr
//   rsp_if: one item per request, status, alloc_addr and free_bytes
//   csr_if: register writes, index 0 lower bound, index 1 upper bound;
//           always ready, write only while no request is in flight
// timing
//   free, unused action and alloc on an empty stack: result registered, valid
//   in the cycle after accept, one item per cycle while the response side keeps up
//   alloc: top entry read into the stack ram read register, answered from ST_READ
//   load: ST_LOAD pushes each page of the range through the stack ram write port
// reset
//   stack becomes empty, bounds return to reset values; ram contents are kept
// stall
//   the response waits in an output register; a new request is taken in ST_IDLE
//   while the register is empty or is being drained in the same cycle
// ---------------------------------------------------------------------------
`include "free_page_stack_allocator_macros.svh"

module free_page_stack_allocator (
   input  logic        clock,
   input  logic        reset,
   fpsa_req_if.sink    req_if,
   fpsa_rsp_if.source  rsp_if,
   fpsa_csr_if.sink    csr_if
);
   import fpsa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PN_W:0]        pn_ff, pn_in;
   logic [ADDR_W-1:0]    lower_ff, lower_in;
   logic [ADDR_W-1:0]    upper_ff, upper_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [BYTES_W-1:0]   rsp_bytes_ff, rsp_bytes_in;

   // stack ram port
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_addr;
   logic [PN_W-1:0]      ram_wdata;
   logic [PN_W-1:0]      ram_rdata;

   logic                 req_acc;
   logic                 stack_full;
   logic                 bad_addr;
   logic                 push_ok;
   logic [COUNT_W-1:0]   count_m1;
   logic [ADDR_W:0]      lower_up;
   logic [PN_W:0]        pn_next;
   logic [PN_W:0]        upper_pn;

   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_acc      = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign stack_full = (count_ff >= COUNT_W'(MAX_PAGES));
   assign count_m1   = count_ff - COUNT_W'(1);

   // free address check: page aligned and inside [lower, upper)
   assign bad_addr = (req_if.page_addr[PAGE_SHIFT-1:0] != '0) ||
                     (req_if.page_addr < lower_ff) ||
                     (req_if.page_addr >= upper_ff);

   assign push_ok = req_acc && (action_type'(req_if.action) == ACT_FREE) &&
                    !bad_addr && !stack_full;

   // lower bound rounded up to a page boundary; its upper bits give the page number
   assign lower_up = {1'b0, lower_ff} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);
   // a page fits while its end stays at or below the upper bound
   assign pn_next  = pn_ff + (PN_W+1)'(1);
   assign upper_pn = {1'b0, upper_ff[ADDR_W-1:PAGE_SHIFT]};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pn_in         = pn_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      ram_we        = 1'b0;
      ram_addr      = count_ff[IDX_W-1:0];
      ram_wdata     = req_if.page_addr[ADDR_W-1:PAGE_SHIFT];

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (action_type'(req_if.action))
                  ACT_FREE: begin
                     rsp_valid_in = 1'b1;
                     rsp_addr_in  = '0;
                     if (bad_addr) begin
                        rsp_status_in = STS_BADADDR;
                     end else if (stack_full) begin
                        rsp_status_in = STS_OVERFLOW;
                     end else begin
                        // push onto the top of the stack
                        ram_we        = 1'b1;
                        count_in      = count_ff + COUNT_W'(1);
                        rsp_status_in = STS_OK;
                     end
                     rsp_bytes_in = bytes_of(count_in);
                  end
                  ACT_ALLOC: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                        rsp_addr_in   = '0;
                        rsp_bytes_in  = bytes_of(count_ff);
                     end else begin
                        // pop: read top entry, answer from ST_READ
                        ram_addr = count_m1[IDX_W-1:0];
                        count_in = count_m1;
                        state_in = ST_READ;
                     end
                  end
                  ACT_LOAD: begin
                     pn_in    = lower_up[ADDR_W:PAGE_SHIFT];
                     state_in = ST_LOAD;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_OK;
                     rsp_addr_in   = '0;
                     rsp_bytes_in  = bytes_of(count_ff);
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STS_OK;
            rsp_addr_in   = {ram_rdata, {PAGE_SHIFT{1'b0}}};
            rsp_bytes_in  = bytes_of(count_ff);
            state_in      = ST_IDLE;
         end
         ST_LOAD: begin
            ram_wdata = pn_ff[PN_W-1:0];
            if (pn_next > upper_pn) begin
               // range walked to the end
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_addr_in   = '0;
               rsp_bytes_in  = bytes_of(count_ff);
               state_in      = ST_IDLE;
            end else if (stack_full) begin
               // remaining pages dropped
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OVERFLOW;
               rsp_addr_in   = '0;
               rsp_bytes_in  = bytes_of(count_ff);
               state_in      = ST_IDLE;
            end else begin
               ram_we   = 1'b1;
               count_in = count_ff + COUNT_W'(1);
               pn_in    = pn_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register writes
   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_index_type'(csr_if.index))
            CSR_LOWER: lower_in = csr_if.data;
            CSR_UPPER: upper_in = csr_if.data;
            default: begin
               lower_in = lower_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lower_ff     <= LOWER_RESET;
         upper_ff     <= UPPER_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
      end
   end

   always_ff @(posedge clock) begin
      pn_ff         <= pn_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

   fpsa_ram #(
      .WIDTH (PN_W),
      .DEPTH (MAX_PAGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.alloc_addr = rsp_addr_ff;
   assign rsp_if.free_bytes = rsp_bytes_ff;

   // checks
   `FPSA_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_W'(MAX_PAGES))
   `FPSA_ASSERT(a_ram_write_src, clock, reset, ram_we |-> (req_acc || state_ff == ST_LOAD))
   `FPSA_ASSERT(a_push_count, clock, reset, push_ok |=> count_ff == $past(count_in))
   `FPSA_ASSERT(a_pop_resp, clock, reset, state_ff == ST_READ |=> rsp_valid_ff)
   `FPSA_ASSERT(a_busy_no_rsp, clock, reset, state_ff != ST_IDLE |-> !rsp_valid_ff)

endmodule

/* rtl/fpsa_ram.sv */
// ---------------------------------------------------------------------------
// fpsa_ram
// single port synchronous ram, registered read
// ---------------------------------------------------------------------------
module fpsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
